// ===== rtl/quad_shell_local_basis_core_defines.svh =====
// assertion helpers shared by the rtl
`ifndef QUAD_SHELL_LOCAL_BASIS_CORE_DEFINES_SVH
`define QUAD_SHELL_LOCAL_BASIS_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QSLB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define QSLB_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define QSLB_ASSERT(name, prop)
`define QSLB_ASSERT_NEVER(name, cond)
`endif
`endif

// ===== rtl/qslb_pkg.sv =====
package qslb_pkg;

  localparam int unsigned MagW       = 64;
  localparam int unsigned FracW      = 30;
  localparam int unsigned PreW       = 30;
  localparam int unsigned UnitW      = 32;
  localparam int unsigned RootSteps  = 32;
  localparam int unsigned RootW      = 32;
  localparam int unsigned QuotBits   = 31;
  localparam int unsigned SumW       = 65;
  localparam int unsigned TruncW     = SumW - FracW;
  localparam int unsigned QueueDepth = 4;

  typedef logic        [MagW-1:0]  mag_t;
  typedef logic signed [MagW-1:0]  wide_t;
  typedef logic signed [UnitW-1:0] unit_t;
  typedef logic signed [PreW:0]    pre_t;

  typedef struct packed {
    logic [5:0] rs;
    logic [4:0] ls;
  } shift_t;

  function automatic mag_t mag_of(wide_t v);
    return v[MagW-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

  // common shift that brings the largest magnitude into [2^29, 2^30)
  function automatic shift_t pre_shift(mag_t orv);
    shift_t r;
    logic [5:0] h;
    h = '0;
    for (int i = 0; i < MagW; i++) begin
      if (orv[i]) h = 6'(i);
    end
    if (h > 6'(PreW - 1)) begin
      r.rs = h - 6'(PreW - 1);
      r.ls = '0;
    end else begin
      r.rs = '0;
      r.ls = 5'(6'(PreW - 1) - h);
    end
    return r;
  endfunction

  function automatic logic [PreW-1:0] pre_apply(mag_t m, shift_t s);
    mag_t t;
    t = (m >> s.rs) << s.ls;
    return t[PreW-1:0];
  endfunction

  // divide by 2^30, truncating toward zero
  function automatic logic signed [TruncW-1:0] q30_trunc(logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] b;
    b = v[SumW-1] ? v + SumW'(2 ** FracW - 1) : v;
    return TruncW'(b >>> FracW);
  endfunction

endpackage

// ===== rtl/qslb_front.sv =====
module qslb_front import qslb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned DiffW = COORD_WIDTH + 1,
  localparam int unsigned PackW = 9 * DiffW
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_WIDTH-1:0] node_i [12],
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [PackW-1:0]              diff_o
);

  logic             valid_q;
  logic [PackW-1:0] diff_d, diff_q;

  // edge vectors: side 1-2, diagonal 3-1, diagonal 4-2
  always_comb begin
    diff_d = '0;
    for (int i = 0; i < 3; i++) begin
      diff_d[i*DiffW +: DiffW]     = DiffW'(node_i[3+i]) - DiffW'(node_i[i]);
      diff_d[(3+i)*DiffW +: DiffW] = DiffW'(node_i[6+i]) - DiffW'(node_i[i]);
      diff_d[(6+i)*DiffW +: DiffW] = DiffW'(node_i[9+i]) - DiffW'(node_i[3+i]);
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign diff_o  = diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      diff_q <= diff_d;
    end
  end

endmodule

// ===== rtl/qslb_queue.sv =====
`include "quad_shell_local_basis_core_defines.svh"

module qslb_queue import qslb_pkg::*; #(
  parameter int unsigned DATA_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [DATA_W-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              push, pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      if (pop) rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      count_q <= CntW'(count_q + CntW'(push) - CntW'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `QSLB_ASSERT_NEVER(a_count_bound, count_q > CntW'(QueueDepth))
  `QSLB_ASSERT(a_ptr_count, PtrW'(wr_ptr_q - rd_ptr_q) == count_q[PtrW-1:0])
  `QSLB_ASSERT_NEVER(a_pop_empty, pop && count_q == '0)

endmodule

// ===== rtl/qslb_norm.sv =====
module qslb_norm import qslb_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  wide_t             vec_i [3],
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output unit_t             unit_o [3],
  output logic              ok_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned SqW = 2 * PreW;

  typedef struct packed {
    logic [2:0]           neg;
    logic [2:0][PreW-1:0] p;
    logic                 ok;
    mag_t                 x;
    mag_t                 r;
  } root_t;

  typedef struct packed {
    logic [2:0]               neg;
    logic [2:0][MagW-1:0]     rem;
    logic [2:0][QuotBits-1:0] q;
    logic [RootW-1:0]         n;
    logic                     ok;
  } quot_t;

  // prescale
  mag_t              m_d [3];
  logic [2:0]        neg_d;
  mag_t              or_d;
  logic              s1_v_q, s2_v_q, s3_v_q;
  mag_t              s1_m_q [3];
  logic [2:0]        s1_neg_q, s2_neg_q, s3_neg_q;
  shift_t            s1_sh_q;
  logic [PreW-1:0]   s2_p_q [3];
  logic [PreW-1:0]   s3_p_q [3];
  logic [SqW-1:0]    s3_sq_q [3];
  logic [SIDE_W-1:0] s1_side_q, s2_side_q, s3_side_q;
  root_t             root_d0;

  // square root and divide chains
  root_t             root_q      [RootSteps+1];
  logic              root_v_q    [RootSteps+1];
  logic [SIDE_W-1:0] root_side_q [RootSteps+1];
  quot_t             quot_q      [QuotBits+1];
  logic              quot_v_q    [QuotBits+1];
  logic [SIDE_W-1:0] quot_side_q [QuotBits+1];
  quot_t             quot_d0;

  logic              out_v_q, out_ok_q;
  unit_t             out_q [3];
  logic [SIDE_W-1:0] out_side_q;

  always_comb begin
    or_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][MagW-1];
      m_d[i]   = mag_of(vec_i[i]);
      or_d     = or_d | m_d[i];
    end
  end

  always_comb begin
    root_d0     = '0;
    root_d0.neg = s3_neg_q;
    for (int i = 0; i < 3; i++) begin
      root_d0.p[i] = s3_p_q[i];
    end
    root_d0.x  = MagW'(s3_sq_q[0]) + MagW'(s3_sq_q[1]) + MagW'(s3_sq_q[2]);
    root_d0.ok = root_d0.x != '0;
  end

  always_comb begin
    quot_d0     = '0;
    quot_d0.neg = root_q[RootSteps].neg;
    quot_d0.ok  = root_q[RootSteps].ok;
    quot_d0.n   = root_q[RootSteps].r[RootW-1:0];
    for (int i = 0; i < 3; i++) begin
      quot_d0.rem[i] = MagW'(root_q[RootSteps].p[i]) << FracW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      root_v_q[0] <= 1'b0;
      quot_v_q[0] <= 1'b0;
      out_v_q     <= 1'b0;
    end else if (en_i) begin
      s1_v_q      <= valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      root_v_q[0] <= s3_v_q;
      quot_v_q[0] <= root_v_q[RootSteps];
      out_v_q     <= quot_v_q[QuotBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_neg_q  <= neg_d;
      s1_sh_q   <= pre_shift(or_d);
      s1_side_q <= side_i;
      s2_neg_q  <= s1_neg_q;
      s2_side_q <= s1_side_q;
      s3_neg_q  <= s2_neg_q;
      s3_side_q <= s2_side_q;
      for (int i = 0; i < 3; i++) begin
        s1_m_q[i]  <= m_d[i];
        s2_p_q[i]  <= pre_apply(s1_m_q[i], s1_sh_q);
        s3_p_q[i]  <= s2_p_q[i];
        s3_sq_q[i] <= SqW'(s2_p_q[i]) * SqW'(s2_p_q[i]);
      end
      root_q[0]      <= root_d0;
      root_side_q[0] <= s3_side_q;
      quot_q[0]      <= quot_d0;
      quot_side_q[0] <= root_side_q[RootSteps];
      out_ok_q       <= quot_q[QuotBits].ok;
      out_side_q     <= quot_side_q[QuotBits];
      for (int i = 0; i < 3; i++) begin
        if (!quot_q[QuotBits].ok) begin
          out_q[i] <= '0;
        end else if (quot_q[QuotBits].neg[i]) begin
          out_q[i] <= -unit_t'({1'b0, quot_q[QuotBits].q[i]});
        end else begin
          out_q[i] <= unit_t'({1'b0, quot_q[QuotBits].q[i]});
        end
      end
    end
  end

  // one result bit of the square root per stage
  for (genvar k = 0; k < RootSteps; k++) begin : g_root
    localparam mag_t Bit = mag_t'(1) << (2 * (RootSteps - 1 - k));
    root_t nx;
    mag_t  trial;

    always_comb begin
      nx    = root_q[k];
      trial = root_q[k].r + Bit;
      if (root_q[k].x >= trial) begin
        nx.x = root_q[k].x - trial;
        nx.r = (root_q[k].r >> 1) + Bit;
      end else begin
        nx.r = root_q[k].r >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        root_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        root_v_q[k+1] <= root_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k+1]      <= nx;
        root_side_q[k+1] <= root_side_q[k];
      end
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar j = 0; j < QuotBits; j++) begin : g_quot
    localparam int unsigned Pos = QuotBits - 1 - j;
    quot_t nx;
    mag_t  dvs;

    always_comb begin
      nx  = quot_q[j];
      dvs = MagW'(quot_q[j].n) << Pos;
      for (int i = 0; i < 3; i++) begin
        if (quot_q[j].rem[i] >= dvs) begin
          nx.rem[i]    = quot_q[j].rem[i] - dvs;
          nx.q[i][Pos] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        quot_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        quot_v_q[j+1] <= quot_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quot_q[j+1]      <= nx;
        quot_side_q[j+1] <= quot_side_q[j];
      end
    end
  end

  assign valid_o = out_v_q;
  assign ok_o    = out_ok_q;
  assign side_o  = out_side_q;
  assign unit_o  = out_q;

endmodule

// ===== rtl/qslb_back.sv =====
module qslb_back import qslb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32,
  localparam int unsigned DiffW = COORD_WIDTH + 1,
  localparam int unsigned PackW = 9 * DiffW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [PackW-1:0] diff_i,
  output logic             valid_o,
  input  logic             ready_i,
  output unit_t            e1_o [3],
  output unit_t            e2_o [3],
  output unit_t            e3_o [3],
  output logic             degenerate_o
);

  localparam int unsigned PreSW   = PreW + 1;
  localparam int unsigned PrdW    = 2 * PreSW;
  localparam int unsigned DotPrdW = PreSW + UnitW;
  localparam int unsigned ASideW  = 3 * PreSW;
  localparam int unsigned ESideW  = 3 * UnitW + 1;

  logic adv;

  // prescale of each edge vector
  mag_t                  b1_m_d [3][3];
  logic [2:0][2:0]       b1_neg_d;
  shift_t                b1_sh_d [3];
  logic                  b1_v_q, b2_v_q, b3_v_q, b4_v_q;
  mag_t                  b1_m_q [3][3];
  logic [2:0][2:0]       b1_neg_q;
  shift_t                b1_sh_q [3];
  pre_t                  b2_a_q [3][3];
  logic signed [PrdW-1:0] b3_prd_q [3][2];
  pre_t                  b3_a21_q [3];
  wide_t                 b4_c_q [3];
  pre_t                  b4_a21_q [3];

  // normal
  logic                  n1_v;
  unit_t                 n1_e3 [3];
  logic                  n1_ok;
  logic [ASideW-1:0]     n1_side;

  // side vector projection
  logic                  d1_v_q, d2_v_q, d3_v_q, d4_v_q, d5_v_q;
  logic signed [DotPrdW-1:0] d1_dp_q [3];
  pre_t                  d1_a_q [3], d2_a_q [3], d3_a_q [3];
  unit_t                 d1_e3_q [3], d2_e3_q [3], d3_e3_q [3], d4_e3_q [3], d5_e3_q [3];
  logic                  d1_ok_q, d2_ok_q, d3_ok_q, d4_ok_q, d5_ok_q;
  logic signed [SumW-1:0]   d2_dot_q;
  logic signed [TruncW-1:0] d3_t_q;
  wide_t                 d4_te_q [3], d4_as_q [3], d5_s_q [3];

  // tangent
  logic                  n2_v;
  unit_t                 n2_e1 [3];
  logic                  n2_ok;
  logic [ESideW-1:0]     n2_side;
  unit_t                 n2_e3 [3];
  logic                  n2_ok1;

  logic                  x1_v_q, x2_v_q;
  wide_t                 x1_prd_q [3][2];
  logic signed [SumW-1:0] x2_dif_q [3];
  unit_t                 x1_e1_q [3], x1_e3_q [3], x2_e1_q [3], x2_e3_q [3];
  logic                  x1_ok_q, x2_ok_q;

  logic                  out_v_q, out_deg_q;
  unit_t                 out_e1_q [3], out_e2_q [3], out_e3_q [3];

  assign adv     = !out_v_q || ready_i;
  assign ready_o = adv;

  always_comb begin
    mag_t acc;
    for (int k = 0; k < 3; k++) begin
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        b1_m_d[k][i]   = mag_of(wide_t'($signed(diff_i[(3*k+i)*DiffW +: DiffW])));
        b1_neg_d[k][i] = diff_i[(3*k+i)*DiffW + DiffW - 1];
        acc            = acc | b1_m_d[k][i];
      end
      b1_sh_d[k] = pre_shift(acc);
    end
  end

  assign n2_e3[0] = n2_side[UnitW-1:0];
  assign n2_e3[1] = n2_side[2*UnitW-1:UnitW];
  assign n2_e3[2] = n2_side[3*UnitW-1:2*UnitW];
  assign n2_ok1   = n2_side[ESideW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      b3_v_q  <= 1'b0;
      b4_v_q  <= 1'b0;
      d1_v_q  <= 1'b0;
      d2_v_q  <= 1'b0;
      d3_v_q  <= 1'b0;
      d4_v_q  <= 1'b0;
      d5_v_q  <= 1'b0;
      x1_v_q  <= 1'b0;
      x2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      b1_v_q  <= valid_i;
      b2_v_q  <= b1_v_q;
      b3_v_q  <= b2_v_q;
      b4_v_q  <= b3_v_q;
      d1_v_q  <= n1_v;
      d2_v_q  <= d1_v_q;
      d3_v_q  <= d2_v_q;
      d4_v_q  <= d3_v_q;
      d5_v_q  <= d4_v_q;
      x1_v_q  <= n2_v;
      x2_v_q  <= x1_v_q;
      out_v_q <= x2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_neg_q <= b1_neg_d;
      for (int k = 0; k < 3; k++) begin
        b1_sh_q[k] <= b1_sh_d[k];
        for (int i = 0; i < 3; i++) begin
          b1_m_q[k][i] <= b1_m_d[k][i];
          if (b1_neg_q[k][i]) begin
            b2_a_q[k][i] <= -pre_t'({1'b0, pre_apply(b1_m_q[k][i], b1_sh_q[k])});
          end else begin
            b2_a_q[k][i] <= pre_t'({1'b0, pre_apply(b1_m_q[k][i], b1_sh_q[k])});
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        b3_prd_q[i][0] <= PrdW'(b2_a_q[1][i == 2 ? 0 : i + 1])
                        * PrdW'(b2_a_q[2][i == 0 ? 2 : i - 1]);
        b3_prd_q[i][1] <= PrdW'(b2_a_q[1][i == 0 ? 2 : i - 1])
                        * PrdW'(b2_a_q[2][i == 2 ? 0 : i + 1]);
        b3_a21_q[i]    <= b2_a_q[0][i];
        b4_c_q[i]      <= wide_t'(b3_prd_q[i][0]) - wide_t'(b3_prd_q[i][1]);
        b4_a21_q[i]    <= b3_a21_q[i];
      end

      d1_ok_q <= n1_ok;
      d2_ok_q <= d1_ok_q;
      d3_ok_q <= d2_ok_q;
      d4_ok_q <= d3_ok_q;
      d5_ok_q <= d4_ok_q;
      for (int i = 0; i < 3; i++) begin
        d1_a_q[i]  <= n1_side[i*PreSW +: PreSW];
        d1_e3_q[i] <= n1_e3[i];
        d1_dp_q[i] <= DotPrdW'($signed(n1_side[i*PreSW +: PreSW])) * DotPrdW'(n1_e3[i]);
        d2_a_q[i]  <= d1_a_q[i];
        d2_e3_q[i] <= d1_e3_q[i];
        d3_a_q[i]  <= d2_a_q[i];
        d3_e3_q[i] <= d2_e3_q[i];
        d4_e3_q[i] <= d3_e3_q[i];
        d4_te_q[i] <= wide_t'(d3_t_q) * wide_t'(d3_e3_q[i]);
        d4_as_q[i] <= wide_t'(d3_a_q[i]) <<< FracW;
        d5_e3_q[i] <= d4_e3_q[i];
        d5_s_q[i]  <= d4_as_q[i] - d4_te_q[i];
      end
      d2_dot_q <= SumW'(d1_dp_q[0]) + SumW'(d1_dp_q[1]) + SumW'(d1_dp_q[2]);
      d3_t_q   <= q30_trunc(d2_dot_q);

      x1_ok_q <= n2_ok && n2_ok1;
      x2_ok_q <= x1_ok_q;
      for (int i = 0; i < 3; i++) begin
        x1_e1_q[i]     <= n2_e1[i];
        x1_e3_q[i]     <= n2_e3[i];
        x1_prd_q[i][0] <= wide_t'(n2_e3[i == 2 ? 0 : i + 1]) * wide_t'(n2_e1[i == 0 ? 2 : i - 1]);
        x1_prd_q[i][1] <= wide_t'(n2_e3[i == 0 ? 2 : i - 1]) * wide_t'(n2_e1[i == 2 ? 0 : i + 1]);
        x2_e1_q[i]     <= x1_e1_q[i];
        x2_e3_q[i]     <= x1_e3_q[i];
        x2_dif_q[i]    <= SumW'(x1_prd_q[i][0]) - SumW'(x1_prd_q[i][1]);
      end

      out_deg_q <= !x2_ok_q;
      for (int i = 0; i < 3; i++) begin
        if (x2_ok_q) begin
          out_e1_q[i] <= x2_e1_q[i];
          out_e2_q[i] <= UnitW'(q30_trunc(x2_dif_q[i]));
          out_e3_q[i] <= x2_e3_q[i];
        end else begin
          out_e1_q[i] <= '0;
          out_e2_q[i] <= '0;
          out_e3_q[i] <= '0;
        end
      end
    end
  end

  qslb_norm #(
    .SIDE_W(ASideW)
  ) u_norm_normal (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b4_v_q),
    .vec_i   (b4_c_q),
    .side_i  ({b4_a21_q[2], b4_a21_q[1], b4_a21_q[0]}),
    .valid_o (n1_v),
    .unit_o  (n1_e3),
    .ok_o    (n1_ok),
    .side_o  (n1_side)
  );

  qslb_norm #(
    .SIDE_W(ESideW)
  ) u_norm_tangent (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d5_v_q),
    .vec_i   (d5_s_q),
    .side_i  ({d5_ok_q, d5_e3_q[2], d5_e3_q[1], d5_e3_q[0]}),
    .valid_o (n2_v),
    .unit_o  (n2_e1),
    .ok_o    (n2_ok),
    .side_o  (n2_side)
  );

  assign valid_o      = out_v_q;
  assign degenerate_o = out_deg_q;
  assign e1_o         = out_e1_q;
  assign e2_o         = out_e2_q;
  assign e3_o         = out_e3_q;

endmodule

// ===== rtl/quad_shell_local_basis_core.sv =====
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    node1_x_i .. node4_z_i
// out       output     out_valid_o / out_ready_i  tangent1_*_o, tangent2_*_o, normal_*_o,
//                                                 degenerate_o
//
// one element per cycle while the output is not stalled; a transaction passes the front register,
// the queue and the back pipeline with its two 32-step square root and 31-step divide pipelines
// rst_ni clears every valid bit and the queue pointers; no clearing pass
// an output stall freezes the back pipeline; the four-entry queue keeps the front taking
// transactions until it fills
`include "quad_shell_local_basis_core_defines.svh"

module quad_shell_local_basis_core import qslb_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] node1_x_i,
  input  logic signed [COORD_WIDTH-1:0] node1_y_i,
  input  logic signed [COORD_WIDTH-1:0] node1_z_i,
  input  logic signed [COORD_WIDTH-1:0] node2_x_i,
  input  logic signed [COORD_WIDTH-1:0] node2_y_i,
  input  logic signed [COORD_WIDTH-1:0] node2_z_i,
  input  logic signed [COORD_WIDTH-1:0] node3_x_i,
  input  logic signed [COORD_WIDTH-1:0] node3_y_i,
  input  logic signed [COORD_WIDTH-1:0] node3_z_i,
  input  logic signed [COORD_WIDTH-1:0] node4_x_i,
  input  logic signed [COORD_WIDTH-1:0] node4_y_i,
  input  logic signed [COORD_WIDTH-1:0] node4_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            tangent1_x_o,
  output logic signed [31:0]            tangent1_y_o,
  output logic signed [31:0]            tangent1_z_o,
  output logic signed [31:0]            tangent2_x_o,
  output logic signed [31:0]            tangent2_y_o,
  output logic signed [31:0]            tangent2_z_o,
  output logic signed [31:0]            normal_x_o,
  output logic signed [31:0]            normal_y_o,
  output logic signed [31:0]            normal_z_o,
  output logic                          degenerate_o
);

  localparam int unsigned PackW = 9 * (COORD_WIDTH + 1);

  logic signed [COORD_WIDTH-1:0] node [12];
  logic                          fr_valid, fr_ready;
  logic [PackW-1:0]              fr_diff;
  logic                          qu_valid, qu_ready;
  logic [PackW-1:0]              qu_diff;
  unit_t                         e1 [3], e2 [3], e3 [3];

  assign node[0]  = node1_x_i;
  assign node[1]  = node1_y_i;
  assign node[2]  = node1_z_i;
  assign node[3]  = node2_x_i;
  assign node[4]  = node2_y_i;
  assign node[5]  = node2_z_i;
  assign node[6]  = node3_x_i;
  assign node[7]  = node3_y_i;
  assign node[8]  = node3_z_i;
  assign node[9]  = node4_x_i;
  assign node[10] = node4_y_i;
  assign node[11] = node4_z_i;

  qslb_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .node_i  (node),
    .valid_o (fr_valid),
    .ready_i (fr_ready),
    .diff_o  (fr_diff)
  );

  qslb_queue #(
    .DATA_W(PackW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_diff),
    .pop_valid_o  (qu_valid),
    .pop_ready_i  (qu_ready),
    .pop_data_o   (qu_diff)
  );

  qslb_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (qu_valid),
    .ready_o      (qu_ready),
    .diff_i       (qu_diff),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .e1_o         (e1),
    .e2_o         (e2),
    .e3_o         (e3),
    .degenerate_o (degenerate_o)
  );

  assign tangent1_x_o = e1[0];
  assign tangent1_y_o = e1[1];
  assign tangent1_z_o = e1[2];
  assign tangent2_x_o = e2[0];
  assign tangent2_y_o = e2[1];
  assign tangent2_z_o = e2[2];
  assign normal_x_o   = e3[0];
  assign normal_y_o   = e3[1];
  assign normal_z_o   = e3[2];

  `QSLB_ASSERT(a_degenerate_zero, out_valid_o && degenerate_o |->
      normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0 && tangent1_x_o == '0)
  `QSLB_ASSERT(a_normal_nonzero, out_valid_o && !degenerate_o |->
      normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
  `QSLB_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(normal_x_o) && $stable(degenerate_o))

endmodule
